[hdl/pbd_pkg.sv]
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared widths, register indexes and letter constants for the periodic
// Bifid decipher.
// ----------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

   // Default capacity of the group buffer, in letters
   localparam int MAX_PERIOD_DEFAULT = 32;

   // Square geometry
   localparam int SIDE  = 5;
   localparam int CELLS = SIDE * SIDE;

   // Field widths
   localparam int CHAR_W   = 8;
   localparam int PLAIN_W  = 7;
   localparam int CODE_W   = 5;
   localparam int DIGIT_W  = 3;
   localparam int CSR_W    = 60;
   localparam int CSR_IX_W = 2;
   localparam int PERIOD_W = 6;
   localparam int CELLS_PER_WORD = 12;

   // Configuration register indexes
   localparam logic [CSR_IX_W-1:0] CSR_CELLS_LOW = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_CELLS_MID = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_CELL_LAST = 2'd2;
   localparam logic [CSR_IX_W-1:0] CSR_PERIOD    = 2'd3;

   // Reset value of the period register
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 6'd5;

   // ASCII and letter codes
   localparam logic [CHAR_W-1:0]  ASCII_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0]  ASCII_UPPER_Z = 8'd90;
   localparam logic [CHAR_W-1:0]  ASCII_LOWER_A = 8'd97;
   localparam logic [CHAR_W-1:0]  ASCII_LOWER_Z = 8'd122;
   localparam logic [CHAR_W-1:0]  CASE_OFFSET   = 8'd32;
   localparam logic [CODE_W-1:0]  CODE_I        = 5'd8;
   localparam logic [CODE_W-1:0]  CODE_J        = 5'd9;
   localparam logic [PLAIN_W-1:0] PLAIN_A       = 7'd65;

endpackage

`default_nettype wire

[hdl/pbd_ram.sv]
// ----------------------------------------------------------------------------
// pbd_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_ram #(
   parameter int WIDTH  = 6,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]  rd_data_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register both reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

[hdl/periodic_bifid_decipher_top.sv]
// ----------------------------------------------------------------------------
// periodic_bifid_decipher_top
// Periodic Bifid decipher over a keyed 5x5 square held in registers.
// ----------------------------------------------------------------------------
// Each ciphertext byte is taken while req_stall is low. Non-letters and
// letters absent from the square are dropped; J is read as I. A letter's row
// and column go into the group buffer, a RAM of MAX_PERIOD entries holding
// one coordinate pair per letter. When the group is full, or msg_end arrives
// with letters held, the group of n letters is emitted as a run of n items.
// Each passes S_READ, presenting both buffer reads, then S_LOAD, using the
// registered read data and held by any output stall; req_stall is high
// throughout. The square and period must be written by software only while
// the block is idle (not enforced). The period is clamped to 1..MAX_PERIOD.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_bifid_decipher_top
   import pbd_pkg::*;
#(
   parameter int MAX_PERIOD = MAX_PERIOD_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // input channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [CHAR_W-1:0]   req_in_char,
   input  wire logic                req_msg_end,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [PLAIN_W-1:0]  rsp_plain_char,
   output logic                     rsp_run_last,
   output logic                     rsp_msg_done,
   // configuration port
   input  wire logic                csr_wr_en,
   input  wire logic [CSR_IX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]    csr_wr_data
);

   localparam int CNT_W  = $clog2(MAX_PERIOD + 1);
   localparam int ADDR_W = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
   localparam int PAIR_W = 2 * DIGIT_W;
   localparam int CMP_W  = 7;
   localparam logic [CMP_W-1:0] MAX_P = CMP_W'(MAX_PERIOD);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_LOAD
   } state_type;

   // Registers
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic                end_ff, end_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PLAIN_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_done_ff, rsp_done_in;
   logic [CSR_W-1:0]    cells_low_ff, cells_mid_ff;
   logic [CODE_W-1:0]   cell_last_ff;
   logic [PERIOD_W-1:0] period_ff;

   // Square and lookup
   logic [CODE_W-1:0]  cells [CELLS];
   logic [CHAR_W-1:0]  folded;
   logic               is_letter;
   logic [CODE_W-1:0]  letter_code;
   logic               found;
   logic [DIGIT_W-1:0] found_row, found_col;
   logic [CMP_W-1:0]   eff_period;

   // Buffer access
   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
   logic [PAIR_W-1:0]  rd_data_a, rd_data_b;
   logic [CNT_W:0]     digit_a, digit_b;
   logic [DIGIT_W-1:0] row_digit, col_digit;
   logic [5:0]         cell_sum;
   logic [5:0]         cell_red;
   logic [CODE_W-1:0]  cell_ix;
   logic [PLAIN_W-1:0] plain;

   // Unpack the square
   always_comb begin
      for (int k = 0; k < CELLS_PER_WORD; k++) begin
         cells[k]                  = cells_low_ff[k*CODE_W +: CODE_W];
         cells[k + CELLS_PER_WORD] = cells_mid_ff[k*CODE_W +: CODE_W];
      end
      cells[CELLS-1] = cell_last_ff;
   end

   // Fold case and map J onto I
   always_comb begin
      folded = req_in_char;
      if (req_in_char >= ASCII_LOWER_A && req_in_char <= ASCII_LOWER_Z) begin
         folded = req_in_char - CASE_OFFSET;
      end
      is_letter   = (folded >= ASCII_UPPER_A) && (folded <= ASCII_UPPER_Z);
      letter_code = CODE_W'(folded - ASCII_UPPER_A);
      if (letter_code == CODE_J) begin
         letter_code = CODE_I;
      end
   end

   // Find the first matching cell; scan downwards so the lowest index wins
   always_comb begin
      logic [CODE_W-1:0] cc;
      found     = 1'b0;
      found_row = '0;
      found_col = '0;
      for (int r = SIDE - 1; r >= 0; r--) begin
         for (int c = SIDE - 1; c >= 0; c--) begin
            cc = cells[r*SIDE + c];
            if (cc == CODE_J) begin
               cc = CODE_I;
            end
            if (cc == letter_code) begin
               found     = 1'b1;
               found_row = DIGIT_W'(r);
               found_col = DIGIT_W'(c);
            end
         end
      end
   end

   // Clamp the period to 1..MAX_PERIOD
   always_comb begin
      priority if (period_ff == '0) begin
         eff_period = CMP_W'(1);
      end else if (CMP_W'(period_ff) > MAX_P) begin
         eff_period = MAX_P;
      end else begin
         eff_period = CMP_W'(period_ff);
      end
   end

   // Digit positions: rows from the first half, columns from the second
   assign digit_a   = {1'b0, pos_ff};
   assign digit_b   = (CNT_W+1)'(count_ff) + (CNT_W+1)'(pos_ff);
   assign rd_addr_a = digit_a[ADDR_W:1];
   assign rd_addr_b = digit_b[ADDR_W:1];

   // Pick each digit from its pair, then reduce the cell index below 25
   always_comb begin
      row_digit = digit_a[0] ? rd_data_a[PAIR_W-1:DIGIT_W] : rd_data_a[DIGIT_W-1:0];
      col_digit = digit_b[0] ? rd_data_b[PAIR_W-1:DIGIT_W] : rd_data_b[DIGIT_W-1:0];
      cell_sum  = 6'({3'b0, row_digit} * 6'(SIDE)) + {3'b0, col_digit};
      cell_red  = (cell_sum >= 6'(CELLS)) ? cell_sum - 6'(CELLS) : cell_sum;
      cell_ix   = cell_red[CODE_W-1:0];
      plain     = PLAIN_A + {2'b0, cells[cell_ix]};
   end

   // Coordinate pair buffer
   pbd_ram #(
      .WIDTH  (PAIR_W),
      .DEPTH  (MAX_PERIOD),
      .ADDR_W (ADDR_W)
   ) u_pair_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (held_ff[ADDR_W-1:0]),
      .wr_data   ({found_col, found_row}),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Sequencer: take items, then read out a group one letter at a time
   always_comb begin
      logic [CNT_W-1:0] held_next;
      logic             slot_free;
      state_in     = state_ff;
      held_in      = held_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      wr_en        = 1'b0;
      held_next    = held_ff;
      slot_free    = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // store the letter if it is in the square and there is room
               if (is_letter && found && (CMP_W'(held_ff) < MAX_P)) begin
                  wr_en     = 1'b1;
                  held_next = held_ff + CNT_W'(1);
               end
               held_in = held_next;
               // close the group when full, or on message end
               if ((CMP_W'(held_next) >= eff_period) ||
                   (req_msg_end && (held_next != '0))) begin
                  count_in = held_next;
                  pos_in   = '0;
                  end_in   = req_msg_end;
                  held_in  = '0;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = plain;
               rsp_last_in  = (pos_ff == count_ff - CNT_W'(1));
               rsp_done_in  = end_ff;
               if (pos_ff == count_ff - CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in   = pos_ff + CNT_W'(1);
                  state_in = S_READ;
               end
            end
         end
      endcase
   end

   // Hold state, configuration and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cells_low_ff <= '0;
         cells_mid_ff <= '0;
         cell_last_ff <= '0;
         period_ff    <= PERIOD_RESET;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_CELLS_LOW: cells_low_ff <= csr_wr_data;
               CSR_CELLS_MID: cells_mid_ff <= csr_wr_data;
               CSR_CELL_LAST: cell_last_ff <= csr_wr_data[CODE_W-1:0];
               CSR_PERIOD:    period_ff    <= csr_wr_data[PERIOD_W-1:0];
            endcase
         end
      end
      count_ff    <= count_in;
      pos_ff      <= pos_in;
      end_ff      <= end_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_char = rsp_char_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_msg_done   = rsp_done_ff;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic Bifid decipher.
// ----------------------------------------------------------------------------
// A local model of the decipher tracks the square, the period and the held
// coordinates, and queues the letters each accepted byte should release.
// Results are compared field by field in order. Directed tests cover the
// reset square, a keyed square with J and case folding, period clamping, a
// period lowered mid-group and odd squares. Random phases follow, each with a
// fresh key and period. Both channels idle at random except in one phase.
// ----------------------------------------------------------------------------

module tb
   import pbd_pkg::*;
();

   localparam int GROUP_MAX     = MAX_PERIOD_DEFAULT;
   localparam int LETTERS       = 26;
   localparam int IDLE_PCT      = 7;
   localparam int SETTLE_CYCLES = 12;
   localparam int HANG_LIMIT    = 4000;

   typedef struct packed {
      logic [PLAIN_W-1:0] plain;
      logic               run_last;
      logic               msg_done;
   } plain_item_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [CHAR_W-1:0]   req_in_char = '0;
   logic                req_msg_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [PLAIN_W-1:0]  rsp_plain_char;
   logic                rsp_run_last;
   logic                rsp_msg_done;
   logic                csr_wr_en   = 1'b0;
   logic [CSR_IX_W-1:0] csr_index   = '0;
   logic [CSR_W-1:0]    csr_wr_data = '0;

   // key the stimulus is built from
   logic [CSR_W-1:0]    key_low    = '0;
   logic [CSR_W-1:0]    key_mid    = '0;
   logic [CODE_W-1:0]   key_last   = '0;
   logic [PERIOD_W-1:0] key_period = PERIOD_RESET;
   logic [CODE_W-1:0]   cell_plan [CELLS];

   // decipher state as the block should hold it
   logic [CSR_W-1:0]    pred_low    = '0;
   logic [CSR_W-1:0]    pred_mid    = '0;
   logic [CODE_W-1:0]   pred_last   = '0;
   logic [PERIOD_W-1:0] pred_period = PERIOD_RESET;
   int                  coord_digits [$];
   plain_item_type      plain_due [$];

   int mismatches   = 0;
   int quiet_cycles = 0;
   bit calm         = 1'b0;

   periodic_bifid_decipher_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_char    (req_in_char),
      .req_msg_end    (req_msg_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_plain_char (rsp_plain_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_msg_done   (rsp_msg_done),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always #4 clock = ~clock;

   // stall the result channel at random, except in the calm stretch
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   function automatic logic [CODE_W-1:0] cell_of(input int i);
      if (i < CELLS_PER_WORD) return pred_low[CODE_W*i +: CODE_W];
      if (i < 2*CELLS_PER_WORD) return pred_mid[CODE_W*(i-CELLS_PER_WORD) +: CODE_W];
      return pred_last;
   endfunction

   // fold, locate and hold one byte; release the group once it is due
   task automatic decipher_byte(input logic [CHAR_W-1:0] ch, input logic fin);
      logic [CHAR_W-1:0] up;
      logic [CODE_W-1:0] cc;
      int                code;
      int                found;
      int                span;
      int                held;
      int                r;
      int                c;
      plain_item_type    item;
      up    = ch;
      code  = -1;
      found = -1;
      span  = (pred_period == 0) ? 1 : (pred_period > GROUP_MAX) ? GROUP_MAX : pred_period;
      if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) up = ch - CASE_OFFSET;
      if (up >= ASCII_UPPER_A && up <= ASCII_UPPER_Z) begin
         code = up - ASCII_UPPER_A;
         if (code == CODE_J) code = CODE_I;
      end
      if (code >= 0) begin
         // first matching cell wins; a J cell also answers for I
         for (int i = 0; i < CELLS && found < 0; i++) begin
            cc = cell_of(i);
            if (cc == CODE_J) cc = CODE_I;
            if (cc == code) found = i;
         end
         if (found >= 0 && coord_digits.size() < 2*GROUP_MAX) begin
            coord_digits = {coord_digits, found / SIDE};
            coord_digits = {coord_digits, found % SIDE};
         end
      end
      held = coord_digits.size() / 2;
      if (held >= span || (fin && held > 0)) begin
         // rows from the first half of the digit string, columns from the second
         for (int b = 0; b < held; b++) begin
            r             = coord_digits[b];
            c             = coord_digits[held+b];
            item.plain    = PLAIN_A + PLAIN_W'(cell_of((r*SIDE + c) % CELLS));
            item.run_last = (b == held - 1);
            item.msg_done = fin;
            plain_due     = {plain_due, item};
         end
         coord_digits.delete();
      end
   endtask

   // track writes and bytes, and check each letter against the oldest due
   always @(posedge clock) begin : check_results
      plain_item_type want;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CELLS_LOW: pred_low    = csr_wr_data;
               CSR_CELLS_MID: pred_mid    = csr_wr_data;
               CSR_CELL_LAST: pred_last   = csr_wr_data[CODE_W-1:0];
               CSR_PERIOD:    pred_period = csr_wr_data[PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) decipher_byte(req_in_char, req_msg_end);
         if (rsp_valid && !rsp_stall) begin
            if (plain_due.size() == 0) begin
               $error("unexpected item: rsp_plain_char %0d", rsp_plain_char);
               mismatches++;
            end else begin
               want = plain_due.pop_front();
               if (rsp_plain_char !== want.plain) begin
                  $error("rsp_plain_char: expected %0d, got %0d", want.plain, rsp_plain_char);
                  mismatches++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $error("rsp_run_last: expected %0d, got %0d", want.run_last, rsp_run_last);
                  mismatches++;
               end
               if (rsp_msg_done !== want.msg_done) begin
                  $error("rsp_msg_done: expected %0d, got %0d", want.msg_done, rsp_msg_done);
                  mismatches++;
               end
            end
         end
      end
   end

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == HANG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic fin);
      int gap;
      gap = 0;
      while (!calm && $urandom_range(99) < IDLE_PCT) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= ch;
      req_msg_end <= fin;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid, let every due letter arrive, then let the block settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (plain_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers; unused high bits carry noise
   task automatic load_key();
      logic [63:0] spare;
      spare       = {$urandom, $urandom};
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_CELLS_LOW;
      csr_wr_data <= key_low;
      @(posedge clock);
      csr_index   <= CSR_CELLS_MID;
      csr_wr_data <= key_mid;
      @(posedge clock);
      csr_index   <= CSR_CELL_LAST;
      csr_wr_data <= {spare[CSR_W-1:CODE_W], key_last};
      @(posedge clock);
      csr_index   <= CSR_PERIOD;
      csr_wr_data <= {spare[CSR_W-1:PERIOD_W], key_period};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic pack_plan();
      for (int i = 0; i < CELLS_PER_WORD; i++) begin
         key_low[CODE_W*i +: CODE_W] = cell_plan[i];
         key_mid[CODE_W*i +: CODE_W] = cell_plan[CELLS_PER_WORD+i];
      end
      key_last = cell_plan[CELLS-1];
   endtask

   // reset square is all A: only A is found; the group fills on the end byte
   task automatic test_blank_square();
      send_byte("A", 1'b0);
      send_byte("b", 1'b0);
      send_byte("a", 1'b0);
      send_byte("#", 1'b0);
      send_byte("A", 1'b0);
      send_byte("a", 1'b0);
      send_byte("A", 1'b1);
      wait_quiet();
   endtask

   // keyed square: J as I, case folding, a flush, and an end with nothing held
   task automatic test_keyed_square();
      string key_text;
      key_text = "PLAYFIREXMBCDGHKNOQSTUVWZ";
      for (int i = 0; i < CELLS; i++) cell_plan[i] = CODE_W'(key_text[i] - "A");
      pack_plan();
      key_period = 6'd5;
      load_key();
      send_byte("J", 1'b0);
      send_byte("z", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte("Q", 1'b0);
      send_byte("m", 1'b0);
      send_byte("k", 1'b0);
      send_byte("x", 1'b1);
      send_byte(8'h00, 1'b1);
      wait_quiet();
   endtask

   // period zero behaves as one
   task automatic test_period_clamp();
      key_period = 6'd0;
      load_key();
      send_byte("P", 1'b0);
      send_byte("l", 1'b0);
      wait_quiet();
   endtask

   // hold four letters, lower the period, release them on a non-letter
   task automatic test_period_lowered();
      key_period = 6'd6;
      load_key();
      send_byte("P", 1'b0);
      send_byte("L", 1'b0);
      send_byte("A", 1'b0);
      send_byte("Y", 1'b0);
      wait_quiet();
      key_period = 6'd2;
      load_key();
      send_byte("@", 1'b0);
      wait_quiet();
   endtask

   // J cell found for I, a missing letter, and cell codes above Z
   task automatic test_odd_square();
      key_low                  = '1;
      key_low[3*CODE_W +: CODE_W] = CODE_J;
      key_mid                  = '1;
      key_mid[0 +: CODE_W]     = CODE_W'(LETTERS);
      key_last                 = CODE_I;
      key_period               = 6'd3;
      load_key();
      send_byte("i", 1'b0);
      send_byte("B", 1'b0);
      send_byte("J", 1'b0);
      send_byte("j", 1'b0);
      wait_quiet();
   endtask

   // phases of random text, each with its own key and period
   task automatic test_random_text();
      logic [CHAR_W-1:0] ch;
      logic [CODE_W-1:0] swap;
      int                letters;
      int                code;
      int                j;
      int                n;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 4) begin
            // noise key: repeats, absent letters and codes above Z
            key_low  = CSR_W'({$urandom, $urandom});
            key_mid  = CSR_W'({$urandom, $urandom});
            key_last = CODE_W'($urandom);
            for (int i = 0; i < CELLS_PER_WORD; i++) begin
               cell_plan[i]                = key_low[CODE_W*i +: CODE_W];
               cell_plan[CELLS_PER_WORD+i] = key_mid[CODE_W*i +: CODE_W];
            end
            cell_plan[CELLS-1] = key_last;
         end else begin
            // shuffled alphabet without J, sometimes J standing for I
            n = 0;
            for (int k = 0; k < LETTERS; k++) begin
               if (k != CODE_J) begin
                  cell_plan[n] = CODE_W'(k);
                  n++;
               end
            end
            for (int i = CELLS - 1; i > 0; i--) begin
               j            = $urandom_range(i);
               swap         = cell_plan[i];
               cell_plan[i] = cell_plan[j];
               cell_plan[j] = swap;
            end
            if ($urandom_range(1)) begin
               for (int i = 0; i < CELLS; i++) if (cell_plan[i] == CODE_I) cell_plan[i] = CODE_J;
            end
            pack_plan();
         end
         case (ph)
            0:       key_period = 6'd63;
            1:       key_period = 6'd32;
            default: key_period = PERIOD_W'($urandom_range(1, 12));
         endcase
         calm = (ph == 2);
         load_key();
         letters = 0;
         while (letters < 22) begin
            if ($urandom_range(99) < 12) begin
               ch = CHAR_W'($urandom_range(255));
            end else begin
               code = cell_plan[$urandom_range(CELLS-1)];
               if (code >= LETTERS) begin
                  ch = ASCII_UPPER_A + CHAR_W'($urandom_range(LETTERS-1));
               end else begin
                  if (code == CODE_I || code == CODE_J) code = $urandom_range(1) ? CODE_I : CODE_J;
                  ch = ASCII_UPPER_A + CHAR_W'(code);
                  letters++;
               end
               if ($urandom_range(1)) ch = ch + CASE_OFFSET;
            end
            send_byte(ch, $urandom_range(99) < 8);
         end
         // flush on odd phases; otherwise carry held letters into the next key
         if (ph % 2 == 1) send_byte(CHAR_W'($urandom_range(255)), 1'b1);
         wait_quiet();
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_blank_square();
      test_keyed_square();
      test_period_clamp();
      test_period_lowered();
      test_odd_square();
      test_random_text();
      wait_quiet();
      if (mismatches == 0 && plain_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
